@@ sv/mrf_pkg.sv @@
// Shared types, constants and the CRC step function for the Modbus RTU
// response framer. Used by every module of the block; depends on nothing.
package mrf_pkg;

    // Default sizes of the block.
    localparam int DEF_MAX_DATA_BYTES = 252;
    localparam int DEF_JOB_DEPTH      = 4;
    localparam int DEF_OUT_DEPTH      = 4;

    // Item kinds on the input channel.
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DATA   = 1'b1;

    // Analysis status codes.
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_BAD_FUNC    = 4'd1;
    localparam logic [3:0] ST_BAD_START   = 4'd2;
    localparam logic [3:0] ST_ADDR_COUNT  = 4'd3;
    localparam logic [3:0] ST_QTY_FIRST   = 4'd4;
    localparam logic [3:0] ST_QTY_LAST    = 4'd7;

    // Function codes and exception codes.
    localparam logic [7:0] FC_READ_COILS  = 8'h01;
    localparam logic [7:0] FC_READ_HOLD   = 8'h03;
    localparam logic [7:0] FC_WRITE_COILS = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS  = 8'h10;
    localparam logic [7:0] EXC_FLAG       = 8'h80;
    localparam logic [7:0] EXC_ILL_FUNC   = 8'h01;
    localparam logic [7:0] EXC_ILL_ADDR   = 8'h02;
    localparam logic [7:0] EXC_ILL_VALUE  = 8'h03;

    // CRC-16/MODBUS.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Width of one output word: frame byte plus end flag.
    localparam int OUT_W = 9;

    // Kind of work handed from the front to the back.
    typedef enum logic [2:0] {
        K_EXC,
        K_READ,
        K_WRITE,
        K_OTHER,
        K_DATA
    } t_kind;

    // One job in the queue between front and back.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  addr;
        logic [7:0]  func;
        logic [7:0]  val;    // exception code, read length or data byte
        logic [15:0] badr;
        logic [15:0] qty;
        logic        last;   // read/data job closes the frame with a CRC
    } t_job;

    localparam int JOB_W = $bits(t_job);

    // One byte through the reflected CRC, eight shift steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in,
                                             input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ sv/mrf_fifo.sv @@
// Small first-in first-out queue of registers with a count-based full flag.
// Uses mrf_pkg for its default width and depth; DEPTH must be a power of two.
module mrf_fifo
    import mrf_pkg::*;
#(
    parameter int WIDTH = JOB_W,
    parameter int DEPTH = DEF_JOB_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             wr_en, rd_en;

    assign o_full    = (r_cnt == CW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign wr_en     = i_wr && !o_full;
    assign rd_en     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd];

    // Storage, written at the tail.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + PW'(1);
            end
            if (rd_en) begin
                r_rd <= r_rd + PW'(1);
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

@@ sv/mrf_front.sv @@
// Front end: accepts header and payload items, tracks the open read frame
// and turns each item into a job for the back end. Depends on mrf_pkg.
module mrf_front
    import mrf_pkg::*;
#(
    parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_cmd,
    input  logic [3:0]  i_status,
    input  logic [7:0]  i_slave_addr,
    input  logic [7:0]  i_func_code,
    input  logic [15:0] i_begin_addr,
    input  logic [15:0] i_quantity,
    input  logic [7:0]  i_byte_count,
    input  logic [7:0]  i_data_byte,
    output logic        o_job_wr,
    output t_job        o_job
);

    localparam logic [7:0] MAX_CNT = 8'(MAX_DATA_BYTES);

    logic       r_in_payload, n_in_payload;
    logic [7:0] r_bytes_left, n_bytes_left;
    logic [7:0] cnt_sat;
    logic       is_exc, is_read, is_write;
    logic [7:0] exc_code;

    // Header classification.
    always_comb begin
        cnt_sat  = (i_byte_count > MAX_CNT) ? MAX_CNT : i_byte_count;
        is_exc   = (i_status >= ST_BAD_FUNC) && (i_status <= ST_QTY_LAST);
        is_read  = (i_status == ST_OK) &&
                   ((i_func_code == FC_READ_COILS) || (i_func_code == FC_READ_HOLD));
        is_write = (i_status == ST_OK) &&
                   ((i_func_code == FC_WRITE_COILS) || (i_func_code == FC_WRITE_REGS));
        if (i_status == ST_BAD_FUNC) begin
            exc_code = EXC_ILL_FUNC;
        end else if ((i_status == ST_BAD_START) || (i_status == ST_ADDR_COUNT)) begin
            exc_code = EXC_ILL_ADDR;
        end else begin
            exc_code = EXC_ILL_VALUE;
        end
    end

    // Job build and frame tracking.
    always_comb begin
        n_in_payload = r_in_payload;
        n_bytes_left = r_bytes_left;
        o_job_wr     = 1'b0;
        o_job.kind   = K_OTHER;
        o_job.addr   = i_slave_addr;
        o_job.func   = i_func_code;
        o_job.val    = i_data_byte;
        o_job.badr   = i_begin_addr;
        o_job.qty    = i_quantity;
        o_job.last   = 1'b0;
        if (i_accept) begin
            if (i_cmd == CMD_DATA) begin
                // A payload byte outside an open read frame is dropped.
                if (r_in_payload && (r_bytes_left != 8'd0)) begin
                    o_job_wr     = 1'b1;
                    o_job.kind   = K_DATA;
                    o_job.last   = (r_bytes_left == 8'd1);
                    n_bytes_left = r_bytes_left - 8'd1;
                    n_in_payload = (r_bytes_left != 8'd1);
                end
            end else begin
                // A header always starts a new frame.
                o_job_wr     = 1'b1;
                n_in_payload = 1'b0;
                n_bytes_left = 8'd0;
                if (is_exc) begin
                    o_job.kind = K_EXC;
                    o_job.val  = exc_code;
                end else if (is_read) begin
                    o_job.kind   = K_READ;
                    o_job.val    = cnt_sat;
                    o_job.last   = (cnt_sat == 8'd0);
                    n_in_payload = (cnt_sat != 8'd0);
                    n_bytes_left = cnt_sat;
                end else if (is_write) begin
                    o_job.kind = K_WRITE;
                end else begin
                    o_job.kind = K_OTHER;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_bytes_left <= 8'd0;
        end else begin
            r_in_payload <= n_in_payload;
            r_bytes_left <= n_bytes_left;
        end
    end

endmodule

@@ sv/mrf_back.sv @@
// Back end: one byte of each job a cycle while a job waits and the output
// queue has room; runs the CRC and queues frame words. Depends on mrf_pkg.
module mrf_back
    import mrf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_empty,
    input  t_job               i_job,
    output logic               o_job_rd,
    input  logic               i_out_full,
    output logic               o_out_wr,
    output logic [OUT_W-1:0]   o_out_word
);

    logic [2:0]  r_step, n_step;
    logic [15:0] r_crc, n_crc;
    logic [3:0]  n_body;
    logic        has_crc;
    logic [3:0]  total;
    logic        at_last;
    logic        in_body;
    logic [15:0] crc_in;
    logic [7:0]  body_byte;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic        go;

    // Frame layout of the current job.
    always_comb begin
        unique case (i_job.kind)
            K_EXC:   begin n_body = 4'd3; has_crc = 1'b1;        end
            K_READ:  begin n_body = 4'd3; has_crc = i_job.last;  end
            K_WRITE: begin n_body = 4'd6; has_crc = 1'b1;        end
            K_OTHER: begin n_body = 4'd2; has_crc = 1'b0;        end
            K_DATA:  begin n_body = 4'd1; has_crc = i_job.last;  end
            default: begin n_body = 4'd2; has_crc = 1'b0;        end
        endcase
        total   = n_body + (has_crc ? 4'd2 : 4'd0);
        at_last = ({1'b0, r_step} == total - 4'd1);
        in_body = ({1'b0, r_step} < n_body);
    end

    // Body byte at the current step.
    always_comb begin
        body_byte = i_job.addr;
        unique case (r_step)
            3'd0: body_byte = (i_job.kind == K_DATA) ? i_job.val : i_job.addr;
            3'd1: body_byte = (i_job.kind == K_EXC) ? (i_job.func + EXC_FLAG) : i_job.func;
            3'd2: body_byte = (i_job.kind == K_WRITE) ? i_job.badr[15:8] : i_job.val;
            3'd3: body_byte = i_job.badr[7:0];
            3'd4: body_byte = i_job.qty[15:8];
            3'd5: body_byte = i_job.qty[7:0];
            default: body_byte = i_job.addr;
        endcase
    end

    // Byte out, CRC and step advance.
    always_comb begin
        go       = !i_job_empty && !i_out_full;
        crc_in   = ((r_step == 3'd0) && (i_job.kind != K_DATA)) ? CRC_INIT : r_crc;
        if (in_body) begin
            out_byte = body_byte;
        end else if ({1'b0, r_step} == n_body) begin
            out_byte = r_crc[7:0];
        end else begin
            out_byte = r_crc[15:8];
        end
        frame_end  = at_last && (has_crc || (i_job.kind == K_OTHER));
        o_out_wr   = go;
        o_out_word = {out_byte, frame_end};
        o_job_rd   = go && at_last;
        n_step     = r_step;
        n_crc      = r_crc;
        if (go) begin
            n_step = at_last ? 3'd0 : r_step + 3'd1;
            if (in_body) begin
                n_crc = crc_byte(crc_in, body_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 3'd0;
            r_crc  <= CRC_INIT;
        end else begin
            r_step <= n_step;
            r_crc  <= n_crc;
        end
    end

endmodule

@@ sv/modbus_rtu_response_framer.sv @@
// Top level of the Modbus RTU response framer: front end, job queue, back
// end and output queue. Depends on mrf_pkg, mrf_front, mrf_fifo, mrf_back.
//
//  Channel   Direction  Handshake          Word
//  items     in         push / full        cmd, status, addresses, counts, data
//  frame     out        pop / empty        out_byte, frame_end
//
// The back end sends one frame byte a cycle unless the job queue is empty or
// the output queue is full, so a payload byte passes at one item a cycle,
// except the closing payload byte, which the two CRC bytes follow. A header
// gives two to eight frame bytes. The job queue lets the front accept items
// while the back end is busy; the output queue keeps the back end going while
// the consumer stalls. With both queues empty, an item is registered in the
// job queue and its first byte in the output queue before it reaches the ports.
// Synchronous active-low reset clears queues, frame tracking and the CRC.
module modbus_rtu_response_framer
    import mrf_pkg::*;
#(
    parameter int MAX_DATA_BYTES = DEF_MAX_DATA_BYTES,
    parameter int JOB_DEPTH      = DEF_JOB_DEPTH,
    parameter int OUT_DEPTH      = DEF_OUT_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [3:0]  i_status,
    input  logic [7:0]  i_slave_addr,
    input  logic [7:0]  i_func_code,
    input  logic [15:0] i_begin_addr,
    input  logic [15:0] i_quantity,
    input  logic [7:0]  i_byte_count,
    input  logic [7:0]  i_data_byte,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end
);

    logic             accept;
    logic             job_wr, job_rd, job_empty;
    t_job             job_in, job_head;
    logic [JOB_W-1:0] job_head_bits;
    logic             out_wr, out_full;
    logic [OUT_W-1:0] out_word, out_head;

    assign accept   = push && !full;
    assign job_head = t_job'(job_head_bits);

    // Front end: classification and frame tracking.
    mrf_front #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd        (i_cmd),
        .i_status     (i_status),
        .i_slave_addr (i_slave_addr),
        .i_func_code  (i_func_code),
        .i_begin_addr (i_begin_addr),
        .i_quantity   (i_quantity),
        .i_byte_count (i_byte_count),
        .i_data_byte  (i_data_byte),
        .o_job_wr     (job_wr),
        .o_job        (job_in)
    );

    // Job queue between front and back.
    mrf_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (job_wr),
        .i_wr_data (job_in),
        .i_rd      (job_rd),
        .o_rd_data (job_head_bits),
        .o_full    (full),
        .o_empty   (job_empty)
    );

    // Back end: byte sequencing and CRC.
    mrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_head),
        .o_job_rd    (job_rd),
        .i_out_full  (out_full),
        .o_out_wr    (out_wr),
        .o_out_word  (out_word)
    );

    // Output queue toward the consumer.
    mrf_fifo #(
        .WIDTH (OUT_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (out_wr),
        .i_wr_data (out_word),
        .i_rd      (pop),
        .o_rd_data (out_head),
        .o_full    (out_full),
        .o_empty   (empty)
    );

    assign o_out_byte  = out_head[OUT_W-1:1];
    assign o_frame_end = out_head[0];

endmodule
